// ----- design/clnc_pkg.sv -----
// Package for the character LCD nibble controller.
// Holds request codes, the job word passed from front to back, and the command tables.
// No dependencies.
`default_nettype none

package clnc_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_MOVE  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_INIT  = 2'd3
  } func_e;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } cfg_reg_e;

  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
  localparam int unsigned INIT_LEN = 7;

  localparam logic [2:0]  ROWS_MAX   = 3'd4;
  localparam logic [5:0]  COLS_MAX   = 6'd40;
  localparam logic [2:0]  ROWS_RESET = 3'd2;
  localparam logic [5:0]  COLS_RESET = 6'd16;

  localparam logic [7:0]  CMD_CLEAR  = 8'h01;
  localparam logic [7:0]  CMD_HOME   = 8'h02;
  localparam logic [7:0]  CMD_ORIGIN = 8'h80;

  localparam logic [10:0] WAIT_LONG  = 11'd2000;
  localparam logic [10:0] WAIT_SHORT = 11'd100;
  localparam logic [10:0] WAIT_NONE  = 11'd0;

  // One queued job: either the init sequence, or one or two bytes.
  typedef struct packed {
    logic       init;
    logic       first_rs;
    logic [7:0] first_byte;
    logic       has_second;
    logic [7:0] second_byte;
  } job_t;

  function automatic logic [7:0] row_base(input logic [1:0] row_idx);
    logic [7:0] base;
    unique case (row_idx)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      default: base = 8'hD4;
    endcase
    return base;
  endfunction

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h0E;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

  // Set-address command for a 1-based cursor position.
  function automatic logic [7:0] addr_cmd(input logic [5:0] col, input logic [2:0] row);
    logic [2:0] row_m1;
    row_m1 = row - 3'd1;
    return row_base(row_m1[1:0]) + {2'b00, col} - 8'd1;
  endfunction

  // Settle time after the low nibble of a byte.
  function automatic logic [10:0] byte_wait(input logic rs, input logic [7:0] b);
    logic [10:0] w;
    if (!rs && (b == CMD_CLEAR || b == CMD_HOME)) w = WAIT_LONG;
    else w = WAIT_SHORT;
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/clnc_front.sv -----
// Front end: configuration registers, cursor tracking and request classification.
// Depends on clnc_pkg; pushes job words into clnc_queue.
`default_nettype none

module clnc_front
  import clnc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [5:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [5:0] target_column_i,
  input  wire logic [2:0] target_row_i,
  input  wire logic       q_full_i,
  output      logic       push_o,
  output      job_t       job_o
);

  logic [2:0] row_count_q;
  logic [5:0] column_count_q;
  logic [5:0] cursor_column_q, cursor_column_d;
  logic [2:0] cursor_row_q, cursor_row_d;
  logic [2:0] eff_rows;
  logic [5:0] eff_cols;
  logic [5:0] adv_col;
  logic [2:0] adv_row;
  logic       adv_ok, move_ok, accept, emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= ROWS_RESET;
      column_count_q <= COLS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROWS: row_count_q    <= cfg_data_i[2:0];
        REG_COLS: column_count_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  always_comb begin
    eff_rows = row_count_q;
    if (row_count_q == 3'd0) eff_rows = 3'd1;
    else if (row_count_q > ROWS_MAX) eff_rows = ROWS_MAX;
    eff_cols = column_count_q;
    if (column_count_q == 6'd0) eff_cols = 6'd1;
    else if (column_count_q > COLS_MAX) eff_cols = COLS_MAX;
  end

  // Advance the cursor, wrapping column into the next row and row back to the top.
  always_comb begin
    adv_col = cursor_column_q + 6'd1;
    adv_row = cursor_row_q;
    if (adv_col > eff_cols) begin
      adv_col = 6'd1;
      adv_row = cursor_row_q + 3'd1;
      if (adv_row > eff_rows) adv_row = 3'd1;
    end
    adv_ok  = (adv_col != 6'd0) && (adv_row != 3'd0)
              && (adv_col <= eff_cols) && (adv_row <= eff_rows);
    move_ok = (target_column_i != 6'd0) && (target_row_i != 3'd0)
              && (target_column_i <= eff_cols) && (target_row_i <= eff_rows);
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    job_o           = '0;
    emit            = 1'b1;
    cursor_column_d = cursor_column_q;
    cursor_row_d    = cursor_row_q;
    unique case (func_e'(func_i))
      FUNC_WRITE: begin
        job_o.first_rs    = 1'b1;
        job_o.first_byte  = char_code_i;
        job_o.has_second  = adv_ok;
        job_o.second_byte = addr_cmd(adv_col, adv_row);
        cursor_column_d   = adv_col;
        cursor_row_d      = adv_row;
      end
      FUNC_MOVE: begin
        // Drop a move outside the display.
        emit             = move_ok;
        job_o.first_byte = addr_cmd(target_column_i, target_row_i);
        if (move_ok) begin
          cursor_column_d = target_column_i;
          cursor_row_d    = target_row_i;
        end
      end
      FUNC_CLEAR: begin
        job_o.first_byte  = CMD_CLEAR;
        job_o.has_second  = 1'b1;
        job_o.second_byte = CMD_ORIGIN;
        cursor_column_d   = 6'd1;
        cursor_row_d      = 3'd1;
      end
      default: begin
        job_o.init      = 1'b1;
        cursor_column_d = 6'd1;
        cursor_row_d    = 3'd1;
      end
    endcase
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_column_q <= 6'd1;
      cursor_row_q    <= 3'd1;
    end else if (accept) begin
      cursor_column_q <= cursor_column_d;
      cursor_row_q    <= cursor_row_d;
    end
  end

  a_row_on_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_row_q != 3'd0 && cursor_row_q <= ROWS_MAX)
    else $error("cursor row left the display");

  a_col_on_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_column_q != 6'd0 && cursor_column_q <= COLS_MAX)
    else $error("cursor column left the display");

endmodule

`default_nettype wire

// ----- design/clnc_queue.sv -----
// Short job queue between front and back ends.
// Depends on clnc_pkg for the job word and depth.
`default_nettype none

module clnc_queue
  import clnc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  input  wire logic pop_i,
  output      job_t pop_job_o,
  output      logic full_o,
  output      logic nonempty_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign nonempty_o = (count_q != '0);
  assign pop_job_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> nonempty_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- design/clnc_back.sv -----
// Back end: walks each job byte by byte, nibble by nibble, into the output register.
// Depends on clnc_pkg; pops job words from clnc_queue.
`default_nettype none

module clnc_back
  import clnc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_nonempty_i,
  input  wire job_t        q_job_i,
  output      logic        pop_o,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        reg_select_o,
  output      logic [3:0]  bus_nibble_o,
  output      logic [10:0] wait_after_us_o,
  output      logic        last_transfer_o
);

  job_t        cur_q;
  logic        busy_q;
  logic [2:0]  idx_q;
  logic        half_q;
  logic [2:0]  last_idx;
  logic [7:0]  cur_byte;
  logic        cur_rs, adv, is_last;
  logic        out_valid_q, rs_q, last_q;
  logic [3:0]  nib_q;
  logic [10:0] wait_q;

  always_comb begin
    if (cur_q.init) last_idx = 3'(INIT_LEN - 1);
    else last_idx = cur_q.has_second ? 3'd1 : 3'd0;
    if (cur_q.init) begin
      cur_byte = init_byte(idx_q);
      cur_rs   = 1'b0;
    end else if (idx_q == 3'd0) begin
      cur_byte = cur_q.first_byte;
      cur_rs   = cur_q.first_rs;
    end else begin
      cur_byte = cur_q.second_byte;
      cur_rs   = 1'b0;
    end
  end

  assign adv     = busy_q && (!out_valid_q || !out_stall_i);
  assign is_last = half_q && (idx_q == last_idx);
  // Take the next job when idle or while the current one hands out its final word.
  assign pop_o   = q_nonempty_i && (!busy_q || (adv && is_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      half_q <= 1'b0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      half_q <= 1'b0;
    end else if (adv) begin
      if (is_last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
        half_q <= 1'b0;
      end else if (half_q) begin
        idx_q  <= idx_q + 3'd1;
        half_q <= 1'b0;
      end else begin
        half_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs_q   <= cur_rs;
      nib_q  <= half_q ? cur_byte[3:0] : cur_byte[7:4];
      wait_q <= half_q ? byte_wait(cur_rs, cur_byte) : WAIT_NONE;
      last_q <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reg_select_o    = rs_q;
  assign bus_nibble_o    = nib_q;
  assign wait_after_us_o = wait_q;
  assign last_transfer_o = last_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= last_idx)
    else $error("byte index ran past the job");

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> wait_q != WAIT_NONE)
    else $error("final word carries no settle time");

endmodule

`default_nettype wire

// ----- design/char_lcd_nibble_controller.sv -----
// Character LCD controller on a 4-bit bus: one request word in, nibble words out.
// A request goes through the job queue and the job register into the output register.
// Throughput: one word per unstalled cycle, set by the nibble sequencer; a write request
//   gives four or two words, move two, clear four, init fourteen; a rejected move none.
// A two-entry job queue lets requests keep arriving while the back end drains.
// Reset (rst_ni low, async): rows 2, columns 16, cursor at column 1 row 1, queue empty.
`default_nettype none

module char_lcd_nibble_controller
  import clnc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [5:0]  cfg_data_i,
  // request words
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [5:0]  target_column_i,
  input  wire logic [2:0]  target_row_i,
  // bus transfer words
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        reg_select_o,
  output      logic [3:0]  bus_nibble_o,
  output      logic [10:0] wait_after_us_o,
  output      logic        last_transfer_o
);

  logic push, pop, q_full, q_nonempty;
  job_t push_job, pop_job;

  // Classify requests, track the cursor, build job words.
  clnc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .char_code_i     (char_code_i),
    .target_column_i (target_column_i),
    .target_row_i    (target_row_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  // Hold pending jobs so either side can stall alone.
  clnc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .full_o     (q_full),
    .nonempty_o (q_nonempty)
  );

  // Split each job into nibble strobes with their settle times.
  clnc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_nonempty_i    (q_nonempty),
    .q_job_i         (pop_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .reg_select_o    (reg_select_o),
    .bus_nibble_o    (bus_nibble_o),
    .wait_after_us_o (wait_after_us_o),
    .last_transfer_o (last_transfer_o)
  );

endmodule

`default_nettype wire

// ----- verif/char_lcd_nibble_controller_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_nibble_controller: request words in, bus nibble words out.
// Depends on clnc_pkg (request and register codes) and the controller RTL; nothing else.

module char_lcd_nibble_controller_tb;
  import clnc_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 8;
  localparam int DRAIN_CYCLES  = 8;     // idle wait in settle() after every owed strobe has been seen
  localparam int QUIET_LIMIT   = 1000;  // cycles with no word moving on either side
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 15;

  localparam logic [10:0] SETTLE_LONG_US  = 11'd2000;
  localparam logic [10:0] SETTLE_SHORT_US = 11'd100;
  localparam logic [10:0] SETTLE_NONE_US  = 11'd0;
  localparam logic [7:0]  BYTE_CLEAR      = 8'h01;
  localparam logic [7:0]  BYTE_HOME       = 8'h02;

  // One nibble strobe as it should appear on the output side.
  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [10:0] wait_us;
    logic        last;
  } xfer_t;

  // Tracks the display cursor and sizes, and holds the strobes still owed by the block.
  class lcd_bus_tracker;
    logic [2:0]  rows_reg;
    logic [5:0]  cols_reg;
    logic [5:0]  cur_col;
    logic [2:0]  cur_row;
    xfer_t       burst[$];
    xfer_t       due_transfers[$];
    int unsigned mismatches;

    function new();
      rows_reg   = 3'd2;
      cols_reg   = 6'd16;
      cur_col    = 6'd1;
      cur_row    = 3'd1;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [5:0] data);
      if (idx == REG_ROWS) rows_reg = data[2:0];
      else cols_reg = data;
    endfunction

    // Clamp the size registers to what the display can hold.
    function logic [2:0] live_rows();
      if (rows_reg == 3'd0) return 3'd1;
      if (rows_reg > 3'd4) return 3'd4;
      return rows_reg;
    endfunction

    function logic [5:0] live_cols();
      if (cols_reg == 6'd0) return 6'd1;
      if (cols_reg > 6'd40) return 6'd40;
      return cols_reg;
    endfunction

    function bit on_screen(logic [5:0] col, logic [2:0] row);
      return col >= 6'd1 && row >= 3'd1 && col <= live_cols() && row <= live_rows();
    endfunction

    function logic [7:0] line_start(logic [1:0] row_idx);
      case (row_idx)
        2'd0:    return 8'h80;
        2'd1:    return 8'hC0;
        2'd2:    return 8'h94;
        default: return 8'hD4;
      endcase
    endfunction

    function logic [7:0] power_up_cmd(int step);
      case (step)
        0:       return 8'h33;
        1:       return 8'h32;
        2:       return 8'h28;
        3:       return 8'h0E;
        4:       return 8'h01;
        5:       return 8'h06;
        default: return 8'h80;
      endcase
    endfunction

    // High nibble with no settle, then low nibble with the byte's settle time.
    function void push_byte(logic rs, logic [7:0] b);
      xfer_t hi;
      xfer_t lo;
      hi.rs      = rs;
      hi.nibble  = b[7:4];
      hi.wait_us = SETTLE_NONE_US;
      hi.last    = 1'b0;
      lo.rs      = rs;
      lo.nibble  = b[3:0];
      lo.wait_us = (!rs && (b == BYTE_CLEAR || b == BYTE_HOME)) ? SETTLE_LONG_US
                                                                : SETTLE_SHORT_US;
      lo.last    = 1'b0;
      burst.push_back(hi);
      burst.push_back(lo);
    endfunction

    function void push_address(logic [5:0] col, logic [2:0] row);
      logic [2:0] row_m1;
      row_m1 = row - 3'd1;
      push_byte(1'b0, line_start(row_m1[1:0]) + {2'b00, col} - 8'd1);
    endfunction

    function void note_request(func_e f, logic [7:0] ch, logic [5:0] tc, logic [2:0] tr);
      burst.delete();
      case (f)
        FUNC_WRITE: begin
          push_byte(1'b1, ch);
          cur_col = cur_col + 6'd1;
          if (cur_col > live_cols()) begin
            cur_col = 6'd1;
            cur_row = cur_row + 3'd1;
            if (cur_row > live_rows()) cur_row = 3'd1;
          end
          // a cursor left off the display by a resize gets no address command
          if (on_screen(cur_col, cur_row)) push_address(cur_col, cur_row);
        end
        FUNC_MOVE: begin
          if (on_screen(tc, tr)) begin
            cur_col = tc;
            cur_row = tr;
            push_address(tc, tr);
          end
        end
        FUNC_CLEAR: begin
          push_byte(1'b0, BYTE_CLEAR);
          cur_col = 6'd1;
          cur_row = 3'd1;
          push_address(6'd1, 3'd1);
        end
        default: begin
          for (int i = 0; i < 7; i++) push_byte(1'b0, power_up_cmd(i));
          cur_col = 6'd1;
          cur_row = 3'd1;
        end
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) due_transfers.push_back(burst[i]);
    endfunction

    function void check_transfer(logic rs, logic [3:0] nib, logic [10:0] wait_us, logic last);
      xfer_t want;
      if (due_transfers.size() == 0) begin
        $error("unexpected bus word: reg_select %0d bus_nibble %h wait_after_us %0d last %0d",
               rs, nib, wait_us, last);
        mismatches++;
        return;
      end
      want = due_transfers.pop_front();
      if (rs !== want.rs) begin
        $error("reg_select: expected %0d, got %0d", want.rs, rs);
        mismatches++;
      end
      if (nib !== want.nibble) begin
        $error("bus_nibble: expected %h, got %h", want.nibble, nib);
        mismatches++;
      end
      if (wait_us !== want.wait_us) begin
        $error("wait_after_us: expected %0d, got %0d", want.wait_us, wait_us);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_transfer: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  // Every block input starts at a known level.
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_index_i     = 1'b0;
  logic [5:0]  cfg_data_i      = 6'd0;
  logic        in_valid_i      = 1'b0;
  logic [1:0]  func_i          = 2'd0;
  logic [7:0]  char_code_i     = 8'd0;
  logic [5:0]  target_column_i = 6'd0;
  logic [2:0]  target_row_i    = 3'd0;
  logic        out_stall_i     = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        reg_select_o;
  logic [3:0]  bus_nibble_o;
  logic [10:0] wait_after_us_o;
  logic        last_transfer_o;

  bit             idle_on    = 1'b1;  // random gaps on both sides while set
  int             stall_left = 0;
  lcd_bus_tracker tracker    = new();

  char_lcd_nibble_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .char_code_i     (char_code_i),
    .target_column_i (target_column_i),
    .target_row_i    (target_row_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .reg_select_o    (reg_select_o),
    .bus_nibble_o    (bus_nibble_o),
    .wait_after_us_o (wait_after_us_o),
    .last_transfer_o (last_transfer_o)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Receiver side: stall in bursts, never while idling is off.
  always @(posedge clk_i) begin
    if (!idle_on) begin
      stall_left  = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left  = $urandom_range(1, 6) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Sample at the falling edge: everything is settled, and a word seen valid
  // and unstalled here moves at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_transfer(reg_select_o, bus_nibble_o, wait_after_us_o, last_transfer_o);
  end

  // Watchdog: give up when no word moves on either side for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("char_lcd_nibble_controller verification failed");
    $finish;
  end

  // Write one size register; call only with nothing in flight.
  task automatic load_reg(cfg_reg_e idx, logic [5:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Drop valid, drain every owed strobe, then cover a rejected move still in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.due_transfers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Present one request word and hold it until the block takes it.
  task automatic send_request(func_e f, logic [7:0] ch, logic [5:0] tc, logic [2:0] tr);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    char_code_i     <= ch;
    target_column_i <= tc;
    target_row_i    <= tr;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    tracker.note_request(f, ch, tc, tr);
    @(posedge clk_i);
  endtask

  // Mostly writes and on-screen moves; some moves anywhere, plus clears and inits.
  task automatic send_random();
    int         pick;
    func_e      f;
    logic [5:0] tc;
    logic [2:0] tr;
    pick = $urandom_range(0, 99);
    tc   = 6'($urandom);
    tr   = 3'($urandom);
    if (pick < 45) begin
      f = FUNC_WRITE;
    end else if (pick < 75) begin
      f = FUNC_MOVE;
      if ($urandom_range(0, 3) != 0) begin
        tc = 6'($urandom_range(1, int'(tracker.live_cols())));
        tr = 3'($urandom_range(1, int'(tracker.live_rows())));
      end
    end else if (pick < 88) begin
      f = FUNC_CLEAR;
    end else begin
      f = FUNC_INIT;
    end
    send_request(f, 8'($urandom), tc, tr);
  endtask

  initial begin
    logic [5:0] rows_val;
    logic [5:0] cols_val;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes (2 rows, 16 columns): init, data extremes, wrap of both
    // column and row, moves rejected for zero and oversize targets, clear.
    send_request(FUNC_INIT,  8'h00, 6'd0,  3'd0);
    send_request(FUNC_WRITE, 8'h00, 6'd0,  3'd0);
    send_request(FUNC_WRITE, 8'hFF, 6'd63, 3'd7);
    send_request(FUNC_MOVE,  8'h00, 6'd16, 3'd2);
    send_request(FUNC_WRITE, 8'h41, 6'd0,  3'd0);
    send_request(FUNC_MOVE,  8'h00, 6'd0,  3'd1);
    send_request(FUNC_MOVE,  8'h00, 6'd1,  3'd0);
    send_request(FUNC_MOVE,  8'h00, 6'd17, 3'd1);
    send_request(FUNC_MOVE,  8'h00, 6'd1,  3'd3);
    send_request(FUNC_MOVE,  8'hFF, 6'd63, 3'd7);
    send_request(FUNC_CLEAR, 8'h00, 6'd0,  3'd0);
    send_request(FUNC_WRITE, 8'h5A, 6'd0,  3'd0);

    // Largest display: bottom-right corner, then wrap back to the origin.
    settle();
    load_reg(REG_ROWS, 6'd4);
    load_reg(REG_COLS, 6'd40);
    send_request(FUNC_MOVE,  8'h00, 6'd40, 3'd4);
    send_request(FUNC_WRITE, 8'h20, 6'd0,  3'd0);
    send_request(FUNC_MOVE,  8'h00, 6'd1,  3'd4);

    // Shrink to one row with the cursor on row 4: writes skip the address command.
    settle();
    load_reg(REG_ROWS, 6'd1);
    send_request(FUNC_WRITE, 8'h41, 6'd0, 3'd0);
    send_request(FUNC_WRITE, 8'h42, 6'd0, 3'd0);

    // Zero sizes act as a single cell.
    settle();
    load_reg(REG_ROWS, 6'd0);
    load_reg(REG_COLS, 6'd0);
    send_request(FUNC_WRITE, 8'h43, 6'd0, 3'd0);
    send_request(FUNC_MOVE,  8'h00, 6'd1, 3'd1);
    send_request(FUNC_MOVE,  8'h00, 6'd2, 3'd1);
    send_request(FUNC_MOVE,  8'h00, 6'd1, 3'd2);

    // Oversize registers clamp to 4 rows and 40 columns.
    settle();
    load_reg(REG_ROWS, 6'd7);
    load_reg(REG_COLS, 6'd63);
    send_request(FUNC_MOVE,  8'h00, 6'd40, 3'd4);
    send_request(FUNC_WRITE, 8'h7E, 6'd0,  3'd0);

    // Random phases, each with its own display size; the third and the last run without gaps.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          rows_val = 6'd4;
          cols_val = 6'd40;
        end
        1: begin
          rows_val = 6'd1;
          cols_val = 6'd1;
        end
        2: begin
          rows_val = 6'($urandom);
          cols_val = 6'($urandom);
        end
        default: begin
          rows_val = 6'($urandom_range(1, 4));
          cols_val = 6'($urandom_range(1, 40));
        end
      endcase
      idle_on = (p != 2) && (p != RANDOM_PHASES - 1);
      load_reg(REG_ROWS, rows_val);
      load_reg(REG_COLS, cols_val);
      repeat (PHASE_WORDS) send_random();
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("char_lcd_nibble_controller verification clean");
    end else begin
      $display("char_lcd_nibble_controller verification failed");
    end
    $finish;
  end

endmodule

// ----- char_lcd_nibble_controller.f -----
design/clnc_pkg.sv
design/clnc_front.sv
design/clnc_queue.sv
design/clnc_back.sv
design/char_lcd_nibble_controller.sv
verif/char_lcd_nibble_controller_tb.sv
